// File: rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chm_pkg: shared types and codes for the chained hash map engine
// Opcodes, status codes and the controller/datapath command and status structs.
// ---------------------------------------------------------------------------
package chm_pkg;

	localparam int KEY_SHIFT = 3;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_SET    = 2'd1,
		OP_GET    = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, read bucket head
		logic rd_node;   // read key/link/value of current node
		logic step;      // advance to link of current node
		logic do_insert; // pop free node, write it, relink head
		logic do_update; // write value of hit node
		logic do_remove; // unlink hit node, push it
		logic rd_stack;  // read free stack top
		logic set_out;   // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_end;    // current reference is 0 or out of range, or walk limit reached
		logic match;     // current node key equals item key
		logic empty;     // free pool exhausted
		op_t  op;
	} stat_t;

endpackage

// File: rtl/chm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chm_datapath: tables, node memories and result register
// Bucket head registers, node key/value/link RAMs, free stack RAM.
// ---------------------------------------------------------------------------
module chm_datapath #(
	parameter int BUCKETS = 16,
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  chm_pkg::cmd_t       cmd,
	output chm_pkg::stat_t      stat,
	input  logic [1:0]          opcode,
	input  logic [63:0]         key,
	input  logic [63:0]         value,
	output logic                found,
	output logic [63:0]         read_value,
	output logic [1:0]          status
);
	import chm_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW = $clog2(ENTRIES + 1);

	// bucket heads are plain registers, cleared at reset
	logic [RW-1:0]   head_q [BUCKETS];

	logic [63:0]   key_mem   [ENTRIES];
	logic [63:0]   val_mem   [ENTRIES];
	logic [RW-1:0] link_mem  [ENTRIES];
	logic [NW-1:0] stack_mem [ENTRIES];
	logic [RW-1:0] low_q; // lowest free count reached; stack below it still holds reset image

	logic [1:0]    op_q;
	logic [63:0]   key_q, val_q;
	logic [BW-1:0] bkt_q;
	logic [RW-1:0] cur_q, prev_q;
	logic [RW-1:0] steps_q;
	logic [RW-1:0] free_q;
	logic [63:0]   nkey_q, nval_q;
	logic [RW-1:0] nlink_q;
	logic [NW-1:0] stk_q;
	logic          hit_q;

	logic [BW-1:0] bkt_in;
	logic [63:0]   shk;
	logic [RW-1:0] head_rd;
	logic [NW-1:0] cur_idx, prev_idx, top_idx, alloc_idx;

	assign shk     = key >> KEY_SHIFT;
	assign bkt_in  = BW'(shk % 64'(BUCKETS));
	assign head_rd = head_q[bkt_in];
	assign cur_idx = NW'(cur_q - RW'(1));
	assign prev_idx = NW'(prev_q - RW'(1));
	assign top_idx = NW'(free_q - RW'(1));
	// stack top at the low-water mark has never been written since reset
	assign alloc_idx = (free_q == low_q) ? NW'(RW'(ENTRIES) - free_q) : stk_q;

	assign stat.at_end = (cur_q == '0) || (cur_q > RW'(ENTRIES)) || (steps_q >= RW'(ENTRIES));
	assign stat.match  = (nkey_q == key_q);
	assign stat.empty  = (free_q == '0);
	assign stat.op     = op_t'(op_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++) head_q[i] <= '0;
			free_q     <= RW'(ENTRIES);
			low_q      <= RW'(ENTRIES);
			hit_q      <= 1'b0;
			found      <= 1'b0;
			status     <= ST_OK;
		end else begin
			if (cmd.load) begin
				hit_q <= 1'b0;
			end
			if (cmd.do_insert) begin
				head_q[bkt_q] <= RW'(alloc_idx) + RW'(1);
				free_q <= free_q - RW'(1);
				if (free_q == low_q) low_q <= free_q - RW'(1);
			end
			if (cmd.do_remove) begin
				if (prev_q == '0) begin
					head_q[bkt_q] <= nlink_q;
				end
				if (free_q < RW'(ENTRIES)) begin
					free_q <= free_q + RW'(1);
				end
			end
			if (cmd.rd_node && !stat.at_end) begin
				hit_q <= 1'b1;
			end
			if (cmd.set_out) begin
				found <= cmd.do_update | cmd.do_remove | (hit_q & stat.match & !stat.at_end);
				if ((op_q == OP_GET || op_q == OP_REMOVE) && !(hit_q && stat.match && !stat.at_end))
					status <= ST_MISS;
				else if ((op_q == OP_PUT || (op_q == OP_SET && !(hit_q && stat.match
						&& !stat.at_end))) && stat.empty)
					status <= ST_FULL;
				else
					status <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			key_q   <= key;
			val_q   <= value;
			bkt_q   <= bkt_in;
			cur_q   <= head_rd;
			prev_q  <= '0;
			steps_q <= '0;
		end
		if (cmd.rd_node) begin
			nkey_q  <= key_mem[cur_idx];
			nval_q  <= val_mem[cur_idx];
			nlink_q <= link_mem[cur_idx];
		end
		if (cmd.step) begin
			prev_q  <= cur_q;
			cur_q   <= nlink_q;
			steps_q <= steps_q + RW'(1);
		end
		if (cmd.rd_stack) begin
			stk_q <= stack_mem[top_idx];
		end
		if (cmd.do_insert) begin
			key_mem[alloc_idx]  <= key_q;
			val_mem[alloc_idx]  <= val_q;
			link_mem[alloc_idx] <= head_q[bkt_q];
		end
		if (cmd.do_update) begin
			val_mem[cur_idx] <= val_q;
		end
		if (cmd.do_remove) begin
			if (prev_q != '0) link_mem[prev_idx] <= nlink_q;
			if (free_q < RW'(ENTRIES)) stack_mem[NW'(free_q)] <= cur_idx;
		end
		if (cmd.set_out) begin
			read_value <= ((op_q == OP_GET || op_q == OP_REMOVE) && hit_q && stat.match
				&& !stat.at_end) ? nval_q : 64'd0;
		end
	end

endmodule

// File: rtl/chm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chm_ctrl: operation sequencer
// Walks the chain one node at a time (read, then compare), then commits and posts the result.
// ---------------------------------------------------------------------------
module chm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  chm_pkg::stat_t stat,
	output chm_pkg::cmd_t  cmd
);
	import chm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_CMP  = 5'b00100,
		S_DONE = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   hit;

	assign hit       = stat.match && !stat.at_end;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_node  = 1'b1;
				cmd.rd_stack = 1'b1;
				state_d = stat.at_end ? S_DONE : S_CMP;
			end
			S_CMP: begin
				if (hit) begin
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.set_out = 1'b1;
					unique case (stat.op)
						OP_PUT:    cmd.do_insert = !stat.empty;
						OP_SET:    begin
							cmd.do_update = hit;
							cmd.do_insert = !hit && !stat.empty;
						end
						OP_REMOVE: cmd.do_remove = hit;
						default:   ;
					endcase
					state_d = S_OUT;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/chained_hash_map_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_map_engine: separate-chaining key/value table
// Bucket = (key >> 3) mod BUCKETS; nodes from a free stack, inserted at head.
// ---------------------------------------------------------------------------
// One operation at a time. The chain walk visits one node at a time (read,
// then compare). The result is posted once the walk stops on a match or runs
// past the last node of the chain or finds the bucket empty; the tables are
// written on the same edge that loads the result register, and a stalled
// earlier result delays that edge. The next item is taken only after the
// result is posted, and not while a posted result is still held by out_stall.
module chained_hash_map_engine #(
	parameter int BUCKETS = 16,
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [63:0] read_value,
	output logic [1:0]  status
);
	import chm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	chm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	chm_datapath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.opcode(opcode), .key(key), .value(value),
		.found(found), .read_value(read_value), .status(status)
	);

endmodule

// File: bench/chained_hash_map_engine_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_map_engine_tb: self-checking bench for the chained hash map
// Drives put/set/get/remove with random gaps and output stalls, predicts
// every result with a behavioral copy of the table and compares in order.
// ---------------------------------------------------------------------------
module chained_hash_map_engine_tb;
	import chm_pkg::*;

	localparam int NBKT = 16;
	localparam int NNODE = 64;

	typedef struct packed {
		logic        found;
		logic [63:0] rd;
		status_t     st;
	} map_reply_t;

	class map_scoreboard;
		logic [6:0]  head [NBKT];
		logic [63:0] nkey [NNODE];
		logic [63:0] nval [NNODE];
		logic [6:0]  nlink [NNODE];
		logic [5:0]  freelist [NNODE];
		int          nfree;
		map_reply_t  pending [$];
		int          errors;
		int          checked;
		int          full_seen, miss_seen, hit_seen;

		function new();
			for (int i = 0; i < NBKT; i++) head[i] = 0;
			for (int i = 0; i < NNODE; i++) freelist[i] = 6'(NNODE - 1 - i);
			nfree = NNODE;
			errors = 0;
			checked = 0;
		endfunction

		function bit take_node(int b, logic [63:0] k, logic [63:0] v);
			int n;
			if (nfree == 0) return 0;
			nfree--;
			n = freelist[nfree];
			nkey[n] = k;
			nval[n] = v;
			nlink[n] = head[b];
			head[b] = 7'(n + 1);
			return 1;
		endfunction

		function void note_request(op_t op, logic [63:0] k, logic [63:0] v);
			map_reply_t r;
			int b, cur, prv, hit, steps;
			b = int'((k >> KEY_SHIFT) % NBKT);
			cur = head[b];
			prv = 0;
			hit = 0;
			steps = 0;
			while (cur != 0 && steps < NNODE) begin
				if (nkey[cur-1] == k) begin
					hit = cur;
					break;
				end
				prv = cur;
				cur = nlink[cur-1];
				steps++;
			end
			r.found = hit != 0;
			r.rd = '0;
			r.st = ST_OK;
			case (op)
				OP_PUT: if (!take_node(b, k, v)) r.st = ST_FULL;
				OP_SET: begin
					if (hit != 0) nval[hit-1] = v;
					else if (!take_node(b, k, v)) r.st = ST_FULL;
				end
				OP_GET: begin
					if (hit != 0) r.rd = nval[hit-1];
					else r.st = ST_MISS;
				end
				default: begin
					if (hit != 0) begin
						r.rd = nval[hit-1];
						if (prv == 0) head[b] = nlink[hit-1];
						else nlink[prv-1] = nlink[hit-1];
						freelist[nfree] = 6'(hit - 1);
						nfree++;
					end else r.st = ST_MISS;
				end
			endcase
			if (r.st == ST_FULL) full_seen++;
			if (r.st == ST_MISS) miss_seen++;
			if (r.found) hit_seen++;
			pending.push_back(r);
		endfunction

		function void check_reply(logic f, logic [63:0] rd, logic [1:0] st);
			map_reply_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result found=%0b read_value=%h status=%0d",
					$time, f, rd, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (f !== e.found) begin
				$display("%0t: found expected %0b actual %0b", $time, e.found, f);
				errors++;
			end
			if (rd !== e.rd) begin
				$display("%0t: read_value expected %h actual %h", $time, e.rd, rd);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  opcode = '0;
	logic [63:0] key = '0;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        found;
	logic [63:0] read_value;
	logic [1:0]  status;

	chained_hash_map_engine uut (.*);

	always #2 clk = ~clk;

	map_scoreboard sb = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_sink = 0;
	logic [63:0] keypool [16];

	// accepted transfers are noted on the same edge the DUT takes them
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(op_t'(opcode), key, value);
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(found, read_value, status);
	end

	always @(posedge clk) begin
		if (hold_sink) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	task automatic send_op(op_t op, logic [63:0] k, logic [63:0] v);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		key <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_replies();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// keys mostly from a small pool so chains collide and lookups hit
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(9);
		if (r < 7) return keypool[$urandom_range(15)];
		if (r < 9) return (rand64() & ~64'h7f) | 64'($urandom_range(7));
		return rand64();
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		int r;
		op_t op;
		src_idle_pct = idle;
		sink_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			op = r < 30 ? OP_PUT : r < 50 ? OP_SET : r < 75 ? OP_GET : OP_REMOVE;
			send_op(op, pick_key(), rand64());
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			keypool[i] = (i < 8) ? 64'(i * 128 + i % 3) : rand64();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: miss on empty, extremes, duplicate put, set update, removes
		send_op(OP_GET, 64'd0, 64'd0);
		send_op(OP_REMOVE, '1, 64'd0);
		send_op(OP_PUT, 64'd0, '1);
		send_op(OP_PUT, '1, 64'd0);
		send_op(OP_PUT, 64'd128, 64'h5555_aaaa_5555_aaaa);
		send_op(OP_PUT, 64'd128, 64'haaaa_5555_aaaa_5555);
		send_op(OP_GET, 64'd128, 64'd0);
		send_op(OP_SET, 64'd0, 64'h1234);
		send_op(OP_SET, 64'd256, 64'h77);
		send_op(OP_GET, 64'd0, 64'd0);
		send_op(OP_REMOVE, 64'd128, 64'd0);
		send_op(OP_GET, 64'd128, 64'd0);
		send_op(OP_REMOVE, 64'd0, 64'd0);
		send_op(OP_REMOVE, 64'd0, 64'd0);
		send_op(OP_GET, '1, 64'd0);
		// fill the pool, then inserts must be refused
		for (int i = 0; i < 66; i++) send_op(OP_PUT, 64'(i * 8), 64'(i));
		send_op(OP_SET, 64'hdead_beef, 64'd1);
		for (int i = 0; i < 66; i++) send_op(OP_REMOVE, 64'(i * 8), 64'd0);
		send_op(OP_REMOVE, 64'd128, 64'd0);
		send_op(OP_REMOVE, '1, 64'd0);
		send_op(OP_REMOVE, 64'd256, 64'd0);
		drain_replies();

		random_phase(350, 0, 0);
		random_phase(350, 56, 0);
		random_phase(350, 0, 56);
		// long sink hold so the engine backs up its input
		fork
			begin
				hold_sink = 1;
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end
			random_phase(40, 0, 0);
		join
		drain_replies();
		random_phase(160, 11, 11);
		drain_replies();

		$display("%0d results checked: %0d hits, %0d misses, %0d pool-full refusals",
			sb.checked, sb.hit_seen, sb.miss_seen, sb.full_seen);
		$display("phases covered idle/stall mixes, a long output hold and a pool fill");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("chained_hash_map_engine_tb passed");
		else
			$display("chained_hash_map_engine_tb failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("chained_hash_map_engine_tb failed");
		$finish;
	end
endmodule
